FILE: rtl/ihx_pkg.sv
// ----------------------------------------------------------------------------
// ihx_pkg: shared types and constants for the Intel HEX record encoder
// Command and store-write records exchanged between front and back ends,
// plus the hex digit and end-record character lookups.
// ----------------------------------------------------------------------------
`default_nettype none

package ihx_pkg;

   localparam int RECORD_BYTES_DEF = 16;

   // Fixed field widths, sized for the largest supported record (32 bytes)
   localparam int CNT_W     = 6;
   localparam int IDX_MAX_W = 5;

   localparam logic OP_DATA   = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_ONE     = 8'h31;
   localparam logic [7:0] CHAR_F       = 8'h46;

   // One record to be written out by the back end
   typedef struct packed {
      logic             is_end;  // end-of-file record, no data
      logic             last;    // final record caused by the input item
      logic             bank;    // store bank holding the data bytes
      logic [CNT_W-1:0] count;
      logic [15:0]      addr;
      logic [7:0]       chk;
   } cmd_type;

   // Store write from the front end
   typedef struct packed {
      logic                 en;
      logic                 bank;
      logic [IDX_MAX_W-1:0] idx;
      logic [7:0]           data;
   } wr_type;

   // Bank handed back once its record is fully written out
   typedef struct packed {
      logic en;
      logic bank;
   } rel_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = 8'h30 + {4'h0, nib};
      end else begin
         c = 8'h37 + {4'h0, nib};
      end
      return c;
   endfunction

   // ":00000001FF\n"
   function automatic logic [7:0] end_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = CHAR_COLON;
         4'd8:    c = CHAR_ONE;
         4'd9:    c = CHAR_F;
         4'd10:   c = CHAR_F;
         4'd11:   c = CHAR_NEWLINE;
         default: c = CHAR_ZERO;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/ihx_if.sv
// ----------------------------------------------------------------------------
// ihx_if: request and response channels of the Intel HEX record encoder
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface ihx_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [7:0]  data_byte;
   logic [15:0] byte_address;

   modport source (output valid, operation, data_byte, byte_address, input ready);
   modport sink   (input valid, operation, data_byte, byte_address, output ready);
endinterface

interface ihx_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last_char;

   modport source (output valid, out_char, last_char, input ready);
   modport sink   (input valid, out_char, last_char, output ready);
endinterface

`default_nettype wire

FILE: rtl/ihx_cmd_q.sv
// ----------------------------------------------------------------------------
// ihx_cmd_q: two-entry record command queue
// Decouples the collecting front end from the character back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ihx_cmd_q (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  ihx_pkg::cmd_type push_cmd,
   input  logic            pop,
   output logic            full,
   output logic            valid,
   output ihx_pkg::cmd_type head
);

   ihx_pkg::cmd_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;

   assign full  = (cnt_ff == 2'd2);
   assign valid = (cnt_ff != 2'd0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/ihx_front.sv
// ----------------------------------------------------------------------------
// ihx_front: item intake and record collection
// Holds one item, tracks the run and fill state, writes bytes into the
// active store bank and queues record commands with a ready checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module ihx_front #(
   parameter int RECORD_BYTES = ihx_pkg::RECORD_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   ihx_req_if.sink          req_ch,
   input  logic             q_full,
   output logic             q_push,
   output ihx_pkg::cmd_type q_cmd,
   output ihx_pkg::wr_type  wr,
   input  ihx_pkg::rel_type rel
);

   localparam int FW = $clog2(RECORD_BYTES + 1);
   localparam logic [FW-1:0] FILL_FULL = FW'(RECORD_BYTES);
   // a jump flush is the item's last record unless the new byte fills a record too
   localparam logic LAST_ON_JUMP = (RECORD_BYTES != 1);

   logic          hold_ff, hold_in;
   logic          op_ff, op_in;
   logic [7:0]    byte_ff, byte_in;
   logic [15:0]   addr_ff, addr_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [15:0]   rec_addr_ff, rec_addr_in;
   logic [15:0]   exp_addr_ff, exp_addr_in;
   logic          run_ff, run_in;
   logic [7:0]    sum_ff, sum_in;
   logic          bank_ff, bank_in;
   logic [1:0]    busy_ff, busy_in;

   logic          is_data, fill_nz, jump, full_after;
   logic [FW-1:0] fill_inc;
   logic [15:0]   new_rec_addr;
   logic [7:0]    sum_new, chk_held, chk_full;

   assign req_ch.ready = ~hold_ff;

   always_comb begin
      is_data      = (op_ff == ihx_pkg::OP_DATA);
      fill_nz      = (fill_ff != '0);
      jump         = run_ff && fill_nz && (addr_ff != exp_addr_ff);
      fill_inc     = fill_ff + FW'(1);
      full_after   = (fill_inc == FILL_FULL);
      new_rec_addr = fill_nz ? rec_addr_ff : addr_ff;
      sum_new      = sum_ff + byte_ff;
      chk_held     = 8'h00 - (8'(fill_ff) + rec_addr_ff[15:8] + rec_addr_ff[7:0] + sum_ff);
      chk_full     = 8'h00 - (8'(FILL_FULL) + new_rec_addr[15:8] + new_rec_addr[7:0]
                              + sum_new);

      hold_in     = hold_ff;
      op_in       = op_ff;
      byte_in     = byte_ff;
      addr_in     = addr_ff;
      fill_in     = fill_ff;
      rec_addr_in = rec_addr_ff;
      exp_addr_in = exp_addr_ff;
      run_in      = run_ff;
      sum_in      = sum_ff;
      bank_in     = bank_ff;
      busy_in     = busy_ff & ~(rel.en ? (2'b01 << rel.bank) : 2'b00);
      q_push      = 1'b0;
      q_cmd       = '0;
      wr          = '0;

      if (!hold_ff) begin
         if (req_ch.valid) begin
            hold_in = 1'b1;
            op_in   = req_ch.operation;
            byte_in = req_ch.data_byte;
            addr_in = req_ch.byte_address;
         end
      end else if ((is_data && jump) || (!is_data && fill_nz)) begin
         // flush the held partial record; the item stays for its next step
         if (!q_full) begin
            q_push          = 1'b1;
            q_cmd.is_end    = 1'b0;
            q_cmd.last      = is_data ? LAST_ON_JUMP : 1'b0;
            q_cmd.bank      = bank_ff;
            q_cmd.count     = ihx_pkg::CNT_W'(fill_ff);
            q_cmd.addr      = rec_addr_ff;
            q_cmd.chk       = chk_held;
            busy_in[bank_ff] = 1'b1;
            bank_in         = ~bank_ff;
            fill_in         = '0;
            sum_in          = 8'h00;
         end
      end else if (is_data) begin
         // store the byte; a full record goes out at once
         if (!busy_ff[bank_ff] && (!full_after || !q_full)) begin
            wr.en       = 1'b1;
            wr.bank     = bank_ff;
            wr.idx      = ihx_pkg::IDX_MAX_W'(fill_ff);
            wr.data     = byte_ff;
            rec_addr_in = new_rec_addr;
            exp_addr_in = addr_ff + 16'd1;
            run_in      = 1'b1;
            hold_in     = 1'b0;
            if (full_after) begin
               q_push           = 1'b1;
               q_cmd.is_end     = 1'b0;
               q_cmd.last       = 1'b1;
               q_cmd.bank       = bank_ff;
               q_cmd.count      = ihx_pkg::CNT_W'(FILL_FULL);
               q_cmd.addr       = new_rec_addr;
               q_cmd.chk        = chk_full;
               busy_in[bank_ff] = 1'b1;
               bank_in          = ~bank_ff;
               fill_in          = '0;
               sum_in           = 8'h00;
            end else begin
               fill_in = fill_inc;
               sum_in  = sum_new;
            end
         end
      end else begin
         // finish with an empty store: end-of-file record
         if (!q_full) begin
            q_push       = 1'b1;
            q_cmd.is_end = 1'b1;
            q_cmd.last   = 1'b1;
            run_in       = 1'b0;
            fill_in      = '0;
            hold_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff     <= 1'b0;
         fill_ff     <= '0;
         rec_addr_ff <= 16'h0000;
         exp_addr_ff <= 16'h0000;
         run_ff      <= 1'b0;
         sum_ff      <= 8'h00;
         bank_ff     <= 1'b0;
         busy_ff     <= 2'b00;
      end else begin
         hold_ff     <= hold_in;
         fill_ff     <= fill_in;
         rec_addr_ff <= rec_addr_in;
         exp_addr_ff <= exp_addr_in;
         run_ff      <= run_in;
         sum_ff      <= sum_in;
         bank_ff     <= bank_in;
         busy_ff     <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      byte_ff <= byte_in;
      addr_ff <= addr_in;
   end

endmodule

`default_nettype wire

FILE: rtl/ihx_back.sv
// ----------------------------------------------------------------------------
// ihx_back: record store and character generator
// Owns the two-bank byte store, pops record commands and writes them out
// one ASCII character per cycle while rsp_ch is ready, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ihx_back #(
   parameter int RECORD_BYTES = ihx_pkg::RECORD_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  ihx_pkg::wr_type  wr,
   input  logic             q_valid,
   input  ihx_pkg::cmd_type q_head,
   output logic             q_pop,
   output ihx_pkg::rel_type rel,
   ihx_rsp_if.source        rsp_ch
);

   localparam int IDX_W     = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
   localparam int POS_W     = $clog2(12 + 2 * RECORD_BYTES);
   localparam int MEM_DEPTH = 2 * (2 ** IDX_W);
   localparam logic [POS_W-1:0] P_DATA = POS_W'(9);
   localparam logic [POS_W-1:0] P_LAST = POS_W'(11);

   logic [7:0] mem [MEM_DEPTH];

   logic             act_ff, act_in;
   ihx_pkg::cmd_type cmd_ff, cmd_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       rd_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       char_ff, char_in;
   logic             last_ff, last_in;

   logic             step, at_end;
   logic [POS_W-1:0] n2, end_pos, d, t, rd_d;
   logic [7:0]       cnt8, ch;
   logic [3:0]       nib;
   logic [IDX_W:0]   rd_addr;

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_char  = char_ff;
   assign rsp_ch.last_char = last_ff;

   // character at the current position
   always_comb begin
      n2      = POS_W'({cmd_ff.count, 1'b0});
      end_pos = cmd_ff.is_end ? P_LAST : P_LAST + n2;
      at_end  = (pos_ff == end_pos);
      d       = pos_ff - P_DATA;
      t       = d - n2;
      cnt8    = 8'(cmd_ff.count);
      nib     = 4'h0;
      case (pos_ff[3:0])
         4'd1:    nib = cnt8[7:4];
         4'd2:    nib = cnt8[3:0];
         4'd3:    nib = cmd_ff.addr[15:12];
         4'd4:    nib = cmd_ff.addr[11:8];
         4'd5:    nib = cmd_ff.addr[7:4];
         4'd6:    nib = cmd_ff.addr[3:0];
         default: nib = 4'h0;
      endcase
      if (cmd_ff.is_end) begin
         ch = ihx_pkg::end_char(pos_ff[3:0]);
      end else if (pos_ff == '0) begin
         ch = ihx_pkg::CHAR_COLON;
      end else if (pos_ff < P_DATA) begin
         ch = ihx_pkg::hex_char(nib);
      end else if (d < n2) begin
         ch = ihx_pkg::hex_char(d[0] ? rd_data_ff[3:0] : rd_data_ff[7:4]);
      end else if (t == '0) begin
         ch = ihx_pkg::hex_char(cmd_ff.chk[7:4]);
      end else if (t == POS_W'(1)) begin
         ch = ihx_pkg::hex_char(cmd_ff.chk[3:0]);
      end else begin
         ch = ihx_pkg::CHAR_NEWLINE;
      end
   end

   always_comb begin
      step  = act_ff && (!rsp_valid_ff || rsp_ch.ready);
      q_pop = !act_ff && q_valid;

      act_in       = act_ff;
      cmd_in       = cmd_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      char_in      = char_ff;
      last_in      = last_ff;
      rel          = '0;

      if (q_pop) begin
         act_in = 1'b1;
         cmd_in = q_head;
         pos_in = '0;
      end
      if (step) begin
         rsp_valid_in = 1'b1;
         char_in      = ch;
         last_in      = at_end && cmd_ff.last;
         if (at_end) begin
            act_in   = 1'b0;
            rel.en   = ~cmd_ff.is_end;
            rel.bank = cmd_ff.bank;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end

      // fetch the byte for the next position so it is ready when that position is reached
      rd_d    = pos_in - P_DATA;
      rd_addr = {cmd_in.bank, rd_d[IDX_W:1]};
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[{wr.bank, wr.idx[IDX_W-1:0]}] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff       <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         act_ff       <= act_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

endmodule

`default_nettype wire

FILE: rtl/intel_hex_record_encoder.sv
// ----------------------------------------------------------------------------
// intel_hex_record_encoder: addressed byte stream to Intel HEX text
// Collects bytes into records of RECORD_BYTES, flushes on address jumps and
// on finish, and writes each record out as ASCII, one character per item.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake     Payload
//  -------  ---  ------------  -------------------------------------------
//  req_ch   in   valid/ready   operation, data_byte[7:0], byte_address[15:0]
//  rsp_ch   out  valid/ready   out_char[7:0], last_char
//
//  Front holds one input item: it accepts the item, then stores the byte or
//  queues the end record, each partial flush adding a step. Back: an n-byte
//  record is 12+2n characters, one per cycle while rsp_ch is ready, plus an
//  idle fetch step before each record; the back end sets the throughput.
//  Reset (synchronous) empties the store and queue; there is no clearing pass.
//  A stalled rsp_ch backs up into the command queue, the store banks, req_ch.
//
`default_nettype none

module intel_hex_record_encoder #(
   parameter int RECORD_BYTES = ihx_pkg::RECORD_BYTES_DEF
) (
   input logic       clock,
   input logic       reset,
   ihx_req_if.sink   req_ch,
   ihx_rsp_if.source rsp_ch
);

   logic             q_push, q_full, q_valid, q_pop;
   ihx_pkg::cmd_type q_cmd, q_head;
   ihx_pkg::wr_type  wr;
   ihx_pkg::rel_type rel;

   // intake, run tracking, bank ownership
   ihx_front #(.RECORD_BYTES(RECORD_BYTES)) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_cmd  (q_cmd),
      .wr     (wr),
      .rel    (rel)
   );

   ihx_cmd_q u_cmd_q (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .full     (q_full),
      .valid    (q_valid),
      .head     (q_head)
   );

   // store banks and text output
   ihx_back #(.RECORD_BYTES(RECORD_BYTES)) u_back (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .q_valid (q_valid),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rel     (rel),
      .rsp_ch  (rsp_ch)
   );

   // commands never pushed into a full queue
   a_q_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("record command pushed into full queue");

   // a bank being emptied by the back end is never refilled or re-queued
   a_wr_bank_owned: assert property (@(posedge clock) disable iff (reset)
      (wr.en && rel.en) |-> (wr.bank != rel.bank))
      else $error("store write into bank still being written out");

   a_push_bank_owned: assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_cmd.is_end && rel.en) |-> (q_cmd.bank != rel.bank))
      else $error("record queued on bank just released");

   // one item held at a time
   a_hold_one: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("second item taken while one is held");

endmodule

`default_nettype wire
